@@ sv/ccx_pkg.sv @@
`default_nettype none

package ccx_pkg;

  localparam int unsigned CCX_DOUBLE_ROUNDS = 10;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_NONCE0 = 3'd4,
    REG_NONCE1 = 3'd5,
    REG_CTR    = 3'd6
  } ccx_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL
  } ccx_fsm_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ccx_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } ccx_out_t;

  typedef logic [15:0][31:0] ccx_words_t;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       step;
    logic       diag;
    logic [1:0] rstep;
    logic       finish;
    logic       emit;
  } ccx_cmd_t;

  typedef struct packed {
    logic need_block;
  } ccx_status_t;

  function automatic logic [31:0] ccx_rotl(input logic [31:0] x, input int unsigned n);
    ccx_rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic ccx_words_t ccx_init(input logic [255:0] key,
                                          input logic [95:0]  nonce,
                                          input logic [31:0]  ctr);
    ccx_words_t w;
    w[0] = SIGMA0;
    w[1] = SIGMA1;
    w[2] = SIGMA2;
    w[3] = SIGMA3;
    for (int i = 0; i < 8; i++) begin
      w[4 + i] = key[32*i +: 32];
    end
    w[12] = ctr;
    w[13] = nonce[31:0];
    w[14] = nonce[63:32];
    w[15] = nonce[95:64];
    ccx_init = w;
  endfunction

endpackage

`default_nettype wire

@@ sv/ccx_ctrl.sv @@
`default_nettype none

module ccx_ctrl import ccx_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = CCX_DOUBLE_ROUNDS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire ccx_status_t status_i,
  output ccx_cmd_t         cmd_o
);

  localparam int unsigned DrW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

  ccx_fsm_e       state_q, state_d;
  logic [1:0]     step_q, step_d;
  logic           diag_q, diag_d;
  logic [DrW-1:0] dr_q, dr_d;
  logic           hold_valid_q, hold_valid_d;
  logic           out_valid_q, out_valid_d;
  logic           emit_ok;
  logic           in_accept;

  assign emit_ok = (state_q == ST_IDLE) && hold_valid_q && !status_i.need_block &&
                   (!out_valid_q || !out_stall_i);
  assign in_stall_o  = hold_valid_q && !emit_ok;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      diag_q       <= 1'b0;
      dr_q         <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      diag_q       <= diag_d;
      dr_q         <= dr_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    diag_d       = diag_q;
    dr_d         = dr_q;
    cmd_o        = '0;
    cmd_o.diag   = diag_q;
    cmd_o.rstep  = step_q;
    cmd_o.capture = in_accept;
    cmd_o.emit   = emit_ok;

    hold_valid_d = in_accept ? 1'b1 : (emit_ok ? 1'b0 : hold_valid_q);
    out_valid_d  = emit_ok ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

    case (state_q)
      ST_IDLE: begin
        if (hold_valid_q && status_i.need_block) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          diag_d     = 1'b0;
          dr_d       = '0;
          state_d    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 2'd1;
        if (step_q == 2'd3) begin
          diag_d = !diag_q;
          if (diag_q) begin
            if (dr_q == DrW'(DOUBLE_ROUNDS - 1)) begin
              state_d = ST_FINAL;
            end else begin
              dr_d = dr_q + DrW'(1);
            end
          end
        end
      end
      ST_FINAL: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/ccx_datapath.sv @@
`default_nettype none

module ccx_datapath import ccx_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire ccx_in_t     in_data_i,
  input  wire ccx_cmd_t    cmd_i,
  output ccx_status_t      status_o,
  output ccx_out_t         out_data_o
);

  logic [255:0] key_q;
  logic [95:0]  nonce_q;
  logic [31:0]  init_ctr_q;

  logic [5:0]   offset_q, offset_d;
  logic [31:0]  block_ctr_q, block_ctr_d;
  logic         msg_start_q, msg_start_d;
  logic         fresh_q, fresh_d;

  ccx_words_t   w_q, w_d;
  ccx_words_t   ks_q, ks_d;
  ccx_words_t   init_load, init_fin, w_step;
  logic [31:0]  ctr_used_q, ctr_used_d, ctr_sel;
  ccx_in_t      hold_q;
  ccx_out_t     out_q, out_d;
  logic [31:0]  ks_word;
  logic [7:0]   ks_byte;

  assign status_o.need_block = msg_start_q || ((offset_q == 6'd0) && !fresh_q);
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      nonce_q    <= '0;
      init_ctr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY0:   key_q[63:0]    <= cfg_data_i;
        REG_KEY1:   key_q[127:64]  <= cfg_data_i;
        REG_KEY2:   key_q[191:128] <= cfg_data_i;
        REG_KEY3:   key_q[255:192] <= cfg_data_i;
        REG_NONCE0: nonce_q[63:0]  <= cfg_data_i;
        REG_NONCE1: nonce_q[95:64] <= cfg_data_i[31:0];
        REG_CTR:    init_ctr_q     <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      block_ctr_q <= '0;
      msg_start_q <= 1'b1;
      fresh_q     <= 1'b0;
    end else begin
      offset_q    <= offset_d;
      block_ctr_q <= block_ctr_d;
      msg_start_q <= msg_start_d;
      fresh_q     <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q      <= w_d;
    ks_q     <= ks_d;
    ctr_used_q <= ctr_used_d;
    out_q    <= out_d;
    if (cmd_i.capture) begin
      hold_q <= in_data_i;
    end
  end

  assign ctr_sel   = msg_start_q ? init_ctr_q : block_ctr_q;
  assign init_load = ccx_init(key_q, nonce_q, ctr_sel);
  assign init_fin  = ccx_init(key_q, nonce_q, ctr_used_q);

  // one add/xor/rotate step of four quarter rounds side by side
  always_comb begin
    logic [1:0]  lane;
    logic [1:0]  o1, o2, o3;
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] s, t;
    w_step = w_q;
    o1 = {1'b0, cmd_i.diag};
    o2 = {cmd_i.diag, 1'b0};
    o3 = {cmd_i.diag, cmd_i.diag};
    for (int l = 0; l < 4; l++) begin
      lane = 2'(l);
      ia = {2'b00, lane};
      ib = {2'b01, lane + o1};
      ic = {2'b10, lane + o2};
      id = {2'b11, lane + o3};
      case (cmd_i.rstep)
        2'd0: begin
          s = w_q[ia] + w_q[ib];
          t = w_q[id] ^ s;
          w_step[ia] = s;
          w_step[id] = ccx_rotl(t, 16);
        end
        2'd1: begin
          s = w_q[ic] + w_q[id];
          t = w_q[ib] ^ s;
          w_step[ic] = s;
          w_step[ib] = ccx_rotl(t, 12);
        end
        2'd2: begin
          s = w_q[ia] + w_q[ib];
          t = w_q[id] ^ s;
          w_step[ia] = s;
          w_step[id] = ccx_rotl(t, 8);
        end
        default: begin
          s = w_q[ic] + w_q[id];
          t = w_q[ib] ^ s;
          w_step[ic] = s;
          w_step[ib] = ccx_rotl(t, 7);
        end
      endcase
    end
  end

  assign ks_word = ks_q[offset_q[5:2]];
  assign ks_byte = ks_word[{offset_q[1:0], 3'b000} +: 8];

  always_comb begin
    w_d         = w_q;
    ks_d        = ks_q;
    ctr_used_d  = ctr_used_q;
    out_d       = out_q;
    offset_d    = offset_q;
    block_ctr_d = block_ctr_q;
    msg_start_d = msg_start_q;
    fresh_d     = fresh_q;

    if (cmd_i.load) begin
      w_d        = init_load;
      ctr_used_d = ctr_sel;
    end
    if (cmd_i.step) begin
      w_d = w_step;
    end
    if (cmd_i.finish) begin
      for (int i = 0; i < 16; i++) begin
        ks_d[i] = w_q[i] + init_fin[i];
      end
      block_ctr_d = ctr_used_q + 32'd1;
      msg_start_d = 1'b0;
      offset_d    = '0;
      fresh_d     = 1'b1;
    end
    if (cmd_i.emit) begin
      out_d.out_byte = hold_q.data_byte ^ ks_byte;
      out_d.last_out = hold_q.last_byte;
      fresh_d        = 1'b0;
      if (hold_q.last_byte) begin
        offset_d    = '0;
        msg_start_d = 1'b1;
      end else begin
        offset_d = offset_q + 6'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/chacha20_stream_xor.sv @@
// Channel  | Direction | Handshake                  | Payload
// input    | in        | in_valid_i / in_stall_o    | in_data_i  (data_byte, last_byte)
// output   | out       | out_valid_o / out_stall_i  | out_data_o (out_byte, last_out)
// config   | in        | cfg_we_i, cfg_idx_i        | cfg_data_i (64)
//
// A byte whose keystream is ready passes through the input register and then the output
// register; the next byte may follow in the next cycle.
// At offset 0 or a message start a new block runs first: a load step, the round steps
// on four shared quarter-round units (one add/xor/rotate step per cycle), a feed-forward
// step, then the byte is emitted.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled output holds; one more byte waits in the input register, then input stalls.
`default_nettype none

module chacha20_stream_xor import ccx_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = CCX_DOUBLE_ROUNDS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ccx_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ccx_out_t         out_data_o
);

  ccx_cmd_t    cmd;
  ccx_status_t status;

  ccx_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ccx_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire

@@ sv/ccx_checker.sv @@
`default_nettype none

module ccx_checker import ccx_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire ccx_in_t     in_data_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire ccx_out_t    out_data_o
);

  logic [1:0] pending_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("output without a pending input transfer");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 2'd0 || pending_q == 2'd1 || pending_q == 2'd2)
    else $error("more than two bytes in flight");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 2'd0 |-> !in_stall_o)
    else $error("input stalled while empty");

endmodule

bind chacha20_stream_xor ccx_checker u_ccx_checker (.*);

`default_nettype wire

@@ verif/chacha20_stream_xor_test.sv @@
`timescale 1ns / 100ps

module chacha20_stream_xor_test;
  import ccx_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_KEY0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  ccx_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  ccx_out_t    out_data_o;

  chacha20_stream_xor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // cipher predictor state
  logic [63:0] key_w [4];
  logic [63:0] nonce_lo;
  logic [31:0] nonce_hi;
  logic [31:0] ctr_init;
  logic [31:0] ks_words [16];
  logic [31:0] mix [16];
  logic [5:0]  ks_offset;
  logic [31:0] blk_ctr;
  bit          msg_start;

  ccx_out_t    cipher_q [$];
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned bytes_seen;
  int unsigned blocks_made;
  int unsigned messages;
  int unsigned settings;
  int unsigned cycles;
  int unsigned stall_left;
  bit          calm;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, cipher_q.size());
      $display("chacha20_stream_xor_test: errors");
      $finish;
    end
  end

  task automatic flag(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void qround(input int a, input int b, input int c, input int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 7);
  endfunction

  function automatic void refresh_keystream();
    logic [31:0] seed [16];
    seed[0] = SIGMA0;
    seed[1] = SIGMA1;
    seed[2] = SIGMA2;
    seed[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      seed[4 + 2*i] = key_w[i][31:0];
      seed[5 + 2*i] = key_w[i][63:32];
    end
    seed[12] = blk_ctr;
    seed[13] = nonce_lo[31:0];
    seed[14] = nonce_lo[63:32];
    seed[15] = nonce_hi;
    for (int i = 0; i < 16; i++) mix[i] = seed[i];
    for (int r = 0; r < CCX_DOUBLE_ROUNDS; r++) begin
      qround(0, 4, 8, 12);
      qround(1, 5, 9, 13);
      qround(2, 6, 10, 14);
      qround(3, 7, 11, 15);
      qround(0, 5, 10, 15);
      qround(1, 6, 11, 12);
      qround(2, 7, 8, 13);
      qround(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + seed[i];
    blocks_made++;
  endfunction

  function automatic ccx_out_t cipher_byte(input ccx_in_t din);
    ccx_out_t    res;
    logic [31:0] word;
    if (msg_start) begin
      blk_ctr   = ctr_init;
      ks_offset = '0;
      msg_start = 1'b0;
    end
    if (ks_offset == 0) begin
      refresh_keystream();
      blk_ctr = blk_ctr + 32'd1;
    end
    word = ks_words[ks_offset[5:2]] >> (ks_offset[1:0] * 8);
    res.out_byte = din.data_byte ^ word[7:0];
    res.last_out = din.last_byte;
    ks_offset = ks_offset + 6'd1;
    if (din.last_byte) begin
      msg_start = 1'b1;
      ks_offset = '0;
      messages++;
    end
    return res;
  endfunction

  // result checking and output stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_q.size() == 0) begin
        flag($sformatf("unexpected result %02h/%0b", out_data_o.out_byte,
                       out_data_o.last_out));
      end else begin
        ccx_out_t want;
        want = cipher_q.pop_front();
        if (out_data_o.out_byte !== want.out_byte)
          flag($sformatf("result %0d: out_byte %02h, expected %02h", bytes_seen,
                         out_data_o.out_byte, want.out_byte));
        if (out_data_o.last_out !== want.last_out)
          flag($sformatf("result %0d: last_out %0b, expected %0b", bytes_seen,
                         out_data_o.last_out, want.last_out));
      end
      bytes_seen++;
    end
    if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // leaves valid high after the transfer; the next call or drain decides
  task automatic send_byte(input logic [7:0] d, input logic fin);
    int unsigned gap;
    ccx_in_t     item;
    gap = pick_gap();
    item.data_byte = d;
    item.last_byte = fin;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    cipher_q.push_back(cipher_byte(item));
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned len, input bit close);
    for (int unsigned i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (idx)
      REG_KEY0:   key_w[0] = v;
      REG_KEY1:   key_w[1] = v;
      REG_KEY2:   key_w[2] = v;
      REG_KEY3:   key_w[3] = v;
      REG_NONCE0: nonce_lo = v;
      REG_NONCE1: nonce_hi = v[31:0];
      REG_CTR:    ctr_init = v[31:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [63:0] n0, input logic [63:0] n1,
                           input logic [63:0] c);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    write_reg(REG_NONCE0, n0);
    write_reg(REG_NONCE1, n1);
    write_reg(REG_CTR, c);
    cfg_we_i <= 1'b0;
    settings++;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b1);
    drain();
  endtask

  task automatic test_field_extremes();
    configure('1, '1, '1, '1, '1, '1, '1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    drain();
  endtask

  // spare index is dropped; upper bits of the 32-bit registers are dropped
  task automatic test_register_edges();
    write_reg(REG_SPARE, {$urandom, $urandom});
    configure(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
              64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
              64'h4a00000000000000, 64'hdeadbeef00000000,
              64'hffffffff00000001);
    write_reg(REG_SPARE, '1);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_byte(8'h4c, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h64, 1'b0);
    send_byte(8'h69, 1'b1);
    drain();
  endtask

  task automatic test_counter_wrap();
    configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              64'h00000000ffffffff);
    send_message(130, 1'b1);
    drain();
  endtask

  // a phase may leave its last message open, so the next key takes over mid-message
  task automatic test_random_traffic(input int unsigned count);
    int unsigned target;
    int unsigned msgs;
    int unsigned len;
    int unsigned r;
    logic [63:0] ctr;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 3);
      ctr = (r == 0) ? 64'hfffffffe : pick_value();
      configure(pick_value(), pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value(), ctr);
      msgs = $urandom_range(1, 4);
      for (int unsigned m = 0; m < msgs; m++) begin
        r = $urandom_range(0, 9);
        len = (r < 7) ? $urandom_range(1, 16) :
              (r < 9) ? $urandom_range(17, 70) : $urandom_range(64, 140);
        send_message(len, !(m == msgs - 1 && $urandom_range(0, 2) == 0));
      end
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_w[i] = '0;
    nonce_lo  = '0;
    nonce_hi  = '0;
    ctr_init  = '0;
    ks_offset = '0;
    blk_ctr   = '0;
    msg_start = 1'b1;
    for (int i = 0; i < 16; i++) ks_words[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_field_extremes();
    test_register_edges();
    test_counter_wrap();
    test_random_traffic(260);
    drain();
    repeat (20) @(posedge clk_i);
    $display("%0d bytes in %0d messages checked against %0d keystream blocks,",
             bytes_seen, messages, blocks_made);
    $display("over %0d key/nonce/counter settings incl. counter wrap and mid-message rekey",
             settings);
    if (errors == 0) begin
      $display("chacha20_stream_xor_test: clean");
    end else begin
      $display("chacha20_stream_xor_test: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ccx_pkg.sv
sv/ccx_ctrl.sv
sv/ccx_datapath.sv
sv/chacha20_stream_xor.sv
sv/ccx_checker.sv
verif/chacha20_stream_xor_test.sv
